// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// antecedent holds, consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`else

`define ASSERT_SAME(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ----- sv/sts_pkg.sv -----
// shared types, constants and the sine table for the dac streamer
package sts_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int PHASE_W = $clog2(TABLE_DEPTH);
	localparam int FRAME_BITS = 16;
	localparam int BIT_POS_W = $clog2(FRAME_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] NIBBLE_RESET = 4'd3;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	typedef enum logic {
		CMD_SINE = 1'b0,
		CMD_VALUE = 1'b1
	} cmd_t;

	typedef logic [7:0] sine_rom_t [TABLE_DEPTH];

	// one framed dac word moving between front and back
	typedef struct packed {
		logic vld;
		logic [FRAME_BITS-1:0] word;
	} frame_t;

	// q30 taylor series of sin on the first quadrant
	function automatic logic [63:0] sine_q30(logic [63:0] r);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		x = (HALF_PI_Q30 * r) / 64'(TABLE_DEPTH);
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		term = ((term * x2) >> 30) / 64'd6;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110;
		sum = (sum >= term) ? sum - term : 64'd0;
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210;
		sum = (sum >= term) ? sum - term : 64'd0;
		return (sum > ONE_Q30) ? ONE_Q30 : sum;
	endfunction

	function automatic logic [7:0] sine_entry(int unsigned i);
		logic [63:0] d;
		logic [63:0] m;
		logic [63:0] r;
		logic [63:0] mag;
		logic [63:0] num;
		logic [63:0] v;
		logic neg;
		d = 64'(TABLE_DEPTH);
		m = 64'(i) << 2;
		// fold to the first quadrant
		if (m <= d) begin
			r = m;
			neg = 1'b0;
		end else if (m <= 2 * d) begin
			r = 2 * d - m;
			neg = 1'b0;
		end else if (m <= 3 * d) begin
			r = m - 2 * d;
			neg = 1'b1;
		end else begin
			r = 4 * d - m;
			neg = 1'b1;
		end
		if (r == 64'd0) begin
			mag = 64'd0;
		end else if (r == d) begin
			mag = ONE_Q30;
		end else begin
			mag = sine_q30(r);
		end
		num = neg ? (64'd1 << 38) - 64'd255 * mag : (64'd1 << 38) + 64'd255 * mag;
		v = num >> 31;
		return (v > 64'd255) ? 8'd255 : v[7:0];
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t t;
		for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
			t[i] = sine_entry(i);
		end
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// ----- sv/sine_table_spi_dac_streamer.sv -----
// top level: sine table / manual code streamer producing serial dac frames
//
//  channel | handshake       | payload
//  --------+-----------------+-------------------------------------
//  input   | push / full     | command, value
//  output  | empty / pop     | mosi_bit, bit_position, last_bit
//  config  | cfg_we          | cfg_wdata (dac control nibble)
//
// each command yields 16 output transfers, one frame bit per cycle while pop
// stays high; the serializer shift register paces the stream. a two-word queue
// lets the front take commands while a frame is still shifting. the first bit
// is visible once the word has been written into the queue and then loaded
// into the serializer. reset clears the phase, queue and serializer and sets
// the nibble to 3; the table is constant logic and needs no fill. a stalled
// pop holds the current bit; a full queue stalls push.
`include "assert_macros.svh"

module sine_table_spi_dac_streamer import sts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	input  logic                 push,
	output logic                 full,
	input  logic                 command,
	input  logic [7:0]           value,
	output logic                 empty,
	input  logic                 pop,
	output logic                 mosi_bit,
	output logic [BIT_POS_W-1:0] bit_position,
	output logic                 last_bit
);

	frame_t front_frame;
	frame_t queue_head;
	logic   queue_rd;
	logic   take;

	assign take = push && !full;

	sts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.command   (command),
		.value     (value),
		.frame     (front_frame)
	);

	sts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_frame),
		.full   (full),
		.rd     (queue_rd),
		.head   (queue_head)
	);

	sts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (queue_head),
		.rd           (queue_rd),
		.empty        (empty),
		.pop          (pop),
		.mosi_bit     (mosi_bit),
		.bit_position (bit_position),
		.last_bit     (last_bit)
	);

	// mid-frame transfer advances the bit position by one
	`ASSERT_NEXT(a_pos_step, clk, arst_n, !empty && pop && !last_bit, !empty && bit_position == $past(bit_position) + 1'b1)
	// an idle serializer picks up a waiting word at once
	`ASSERT_NEXT(a_load_idle, clk, arst_n, empty && queue_head.vld, !empty && bit_position == '0)
	// last bit done with a word waiting starts the next frame without a gap
	`ASSERT_NEXT(a_no_gap, clk, arst_n, !empty && pop && last_bit && queue_head.vld, !empty && bit_position == '0)
	// the queue never reads while nothing is waiting
	`ASSERT_SAME(a_rd_vld, clk, arst_n, queue_rd, queue_head.vld)

endmodule

// ----- sv/sts_front.sv -----
// front end: takes commands, looks up the sine table or passes the manual value, and builds the dac word
module sts_front import sts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	input  logic                 take,
	input  logic                 command,
	input  logic [7:0]           value,
	output frame_t               frame
);

	logic [PHASE_W-1:0] phase_q;
	logic [3:0]         nibble_q;
	logic [7:0]         data_byte;
	logic               is_sine;

	assign is_sine = (cmd_t'(command) == CMD_SINE);
	assign data_byte = is_sine ? SINE_ROM[phase_q] : value;

	assign frame.vld = take;
	assign frame.word = {nibble_q, data_byte, 4'b0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			nibble_q <= NIBBLE_RESET;
		end else begin
			if (cfg_we) begin
				nibble_q <= cfg_wdata;
			end
			// the phase only moves on a sine request
			if (take && is_sine) begin
				if (phase_q == PHASE_W'(TABLE_DEPTH - 1)) begin
					phase_q <= '0;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

endmodule

// ----- sv/sts_queue.sv -----
// short word queue between the front end and the serializer
module sts_queue import sts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  frame_t wr,
	output logic   full,
	input  logic   rd,
	output frame_t head
);

	logic [FRAME_BITS-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head.vld = (cnt_q != '0);
	assign head.word = mem_q[rd_ptr_q];
	assign do_wr = wr.vld && !full;
	assign do_rd = rd && head.vld;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/sts_back.sv -----
// back end: shifts each dac word out msb first, one bit per transfer
module sts_back import sts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  frame_t               head,
	output logic                 rd,
	output logic                 empty,
	input  logic                 pop,
	output logic                 mosi_bit,
	output logic [BIT_POS_W-1:0] bit_position,
	output logic                 last_bit
);

	logic [FRAME_BITS-1:0] word_q;
	logic [BIT_POS_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  xfer;
	logic                  at_last;

	assign at_last = (cnt_q == BIT_POS_W'(FRAME_BITS - 1));
	assign xfer = pop && busy_q;
	// reload when idle, or straight after the last bit leaves
	assign rd = head.vld && (!busy_q || (xfer && at_last));

	assign empty = !busy_q;
	assign mosi_bit = word_q[FRAME_BITS-1];
	assign bit_position = cnt_q;
	assign last_bit = at_last;

	always_ff @(posedge clk) begin
		if (rd) begin
			word_q <= head.word;
		end else if (xfer) begin
			word_q <= {word_q[FRAME_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (rd) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (xfer) begin
			if (at_last) begin
				busy_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule
